// ===== rtl/core/stg_pkg.sv =====
// Shared constants and the quarter-wave sine table function for the tone generator.
`default_nettype none

package stg_pkg;

  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PHASE_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_AMPLITUDE  = 3'd4;

  localparam logic [15:0] SAMPLE_MAX    = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MIN    = 16'h8000;
  localparam logic [16:0] NEG_MAG_LIMIT = 17'd32768;
  localparam logic [16:0] POS_MAG_LIMIT = 17'd32767;

  localparam logic [63:0] FULL_SCALE = 64'd32768;
  localparam logic [63:0] HALF_Q30   = 64'd536870912;

  // Taylor terms of sin(pi/2 * x) in Q30, x^1 up to x^11
  localparam logic [63:0] SINE_COEF [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569278,
    64'd5026990,    64'd172272,    64'd3864
  };

  // sin(pi/2 * k / 2^tab_bits) in Q1.15, clamped to 32768
  function automatic logic [15:0] quarter_sine(input int unsigned k,
                                               input int unsigned tab_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] q15;
    int unsigned kk;
    kk = k;
    if (kk > (32'd1 << tab_bits)) begin
      kk = 32'd1 << tab_bits;
    end
    x  = 64'(kk) << (30 - tab_bits);
    x2 = (x * x) >> 30;
    p  = SINE_COEF[5];
    for (int i = 4; i >= 0; i--) begin
      p = SINE_COEF[i] - ((x2 * p) >> 30);
    end
    s   = (x * p) >> 30;
    q15 = (s * FULL_SCALE + HALF_Q30) >> 30;
    if (q15 > FULL_SCALE) begin
      q15 = FULL_SCALE;
    end
    return q15[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stg_front.sv =====
// Front end: phase accumulator and table address generation per sample tick.
`default_nettype none

module stg_front #(
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_restart,
  input  wire logic [31:0]              phase_step,
  input  wire logic                     q_full,
  output logic                          q_push,
  output logic [TABLE_ADDR_BITS+1:0]    q_data
);

  localparam int unsigned ADDR_W = TABLE_ADDR_BITS + 1;
  localparam logic [ADDR_W-1:0] QUARTER = ADDR_W'(1) << TABLE_ADDR_BITS;

  logic [PHASE_BITS-1:0]      acc_r;
  logic [PHASE_BITS-1:0]      acc_nxt;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] k;
  logic [ADDR_W-1:0]          addr;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    phase_cur = in_restart ? '0 : acc_r;
    quad      = phase_cur[PHASE_BITS-1 -: 2];
    k         = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    // mirror the address on the falling quarters
    addr      = quad[0] ? (QUARTER - {1'b0, k}) : {1'b0, k};
    q_data    = {quad[1], addr};
    acc_nxt   = q_push ? (phase_cur + PHASE_BITS'(phase_step)) : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stg_queue.sv =====
// Short queue between the address front end and the table and gain back end.
`default_nettype none

module stg_queue #(
  parameter int unsigned DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   empty
);

  localparam int unsigned DEPTH = stg_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stg_back.sv =====
// Back end: sine table read, amplitude multiply, sign and saturation, output register.
`default_nettype none

module stg_back #(
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire logic [TABLE_ADDR_BITS+1:0] q_data,
  output logic                            q_pop,
  input  wire logic [15:0]                amplitude,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [15:0]              out_sample
);

  localparam int unsigned ADDR_W    = TABLE_ADDR_BITS + 1;
  localparam int unsigned ROM_DEPTH = (1 << TABLE_ADDR_BITS) + 1;

  logic [15:0] rom [ROM_DEPTH];

  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
    assign rom[i] = stg_pkg::quarter_sine(i, TABLE_ADDR_BITS);
  end

  logic              a_valid_r;
  logic              a_neg_r;
  logic [15:0]       a_mag_r;
  logic              b_valid_r;
  logic              b_neg_r;
  logic [16:0]       b_mag_r;
  logic              c_valid_r;
  logic signed [15:0] c_sample_r;
  logic signed [15:0] c_sample_nxt;
  logic              a_ready;
  logic              b_ready;
  logic              c_ready;
  logic [31:0]       prod;
  logic [ADDR_W-1:0] rd_addr;

  assign c_ready = !c_valid_r || out_ready;
  assign b_ready = !b_valid_r || c_ready;
  assign a_ready = !a_valid_r || b_ready;
  assign q_pop   = !q_empty && a_ready;
  assign rd_addr = q_data[ADDR_W-1:0];

  assign prod = 32'(amplitude) * 32'(a_mag_r);

  always_comb begin
    // clip at full scale; the negative peak fits exactly
    if (b_neg_r) begin
      c_sample_nxt = (b_mag_r > stg_pkg::NEG_MAG_LIMIT) ? stg_pkg::SAMPLE_MIN
                                                         : -b_mag_r[15:0];
    end else begin
      c_sample_nxt = (b_mag_r > stg_pkg::POS_MAG_LIMIT) ? stg_pkg::SAMPLE_MAX
                                                         : b_mag_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= q_pop;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_mag_r <= rom[rd_addr];
      a_neg_r <= q_data[ADDR_W];
    end
    if (a_valid_r && b_ready) begin
      b_mag_r <= prod[31:15];
      b_neg_r <= a_neg_r;
    end
    if (b_valid_r && c_ready) begin
      c_sample_r <= c_sample_nxt;
    end
  end

  assign out_valid  = c_valid_r;
  assign out_sample = c_sample_r;

endmodule

`default_nettype wire

// ===== rtl/core/sine_tone_generator.sv =====
// Top level of the sine tone generator: register file, front end, queue and back end.
//
//  port group  | handshake                      | payload
//  ------------+--------------------------------+---------------------------------
//  input       | in_valid / in_ready            | in_restart (1 bit)
//  output      | out_valid / out_ready          | out_sample (signed 16 bits)
//  register    | psel, penable, pwrite, pready  | paddr[2:0], pwdata, prdata
//
//  One item per clock sustained while out_ready stays high. From acceptance to out_valid:
//  the queue is written at the accepting edge, then table read, multiply, and saturate
//  into the output register.
//  Synchronous reset clears the phase, the registers, the queue and all stage valids.
//  The four-entry queue lets the front end keep taking items while out_ready is low,
//  until the back end's three stages and the queue are full.
`default_nettype none

module sine_tone_generator #(
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [15:0]                 out_sample,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [stg_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned Q_W = TABLE_ADDR_BITS + 2;

  logic [31:0]    phase_step_r;
  logic [15:0]    amplitude_r;
  logic           wr_en;
  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_full;
  logic           q_pop;
  logic [Q_W-1:0] q_pop_data;
  logic           q_empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // decode on the word bit only; byte offsets alias
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      amplitude_r  <= '0;
    end else if (wr_en) begin
      if (paddr[2] == stg_pkg::ADDR_AMPLITUDE[2]) begin
        amplitude_r <= pwdata[15:0];
      end else begin
        phase_step_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (paddr[2] == stg_pkg::ADDR_AMPLITUDE[2]) begin
      prdata = {16'd0, amplitude_r};
    end else begin
      prdata = phase_step_r;
    end
  end

  stg_front #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .phase_step (phase_step_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  stg_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  stg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_pop_data),
    .q_pop      (q_pop),
    .amplitude  (amplitude_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sine tone generator: directed table, then random ticks.
module tb_top;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 7;
  localparam int TAB_BITS    = stg_pkg::TABLE_ADDR_BITS_DEF;
  localparam int PH_BITS     = stg_pkg::PHASE_BITS_DEF;
  localparam int QUARTER     = 1 << TAB_BITS;
  localparam int PHASES      = 8;
  localparam int TICKS_PER_PHASE = 50;
  localparam int LONG_HOLD   = 60;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;

  // sin(pi/2 * x) Taylor terms in Q30, odd powers 1..11
  localparam logic [63:0] TAYLOR_Q30 [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569278,
    64'd5026990,    64'd172272,    64'd3864
  };

  typedef enum logic [1:0] {ROW_TICK, ROW_SET_STEP, ROW_SET_AMP} row_kind_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_mode_t;

  typedef struct {
    row_kind_t          kind;
    logic [31:0]        value;
    bit                 restart;
    bit                 typed;
    logic signed [15:0] sample;
  } tone_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [stg_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // oscillator mirror
  logic [PH_BITS-1:0] osc_phase = '0;
  logic [31:0]        osc_step = '0;
  logic [15:0]        osc_gain = '0;
  logic [15:0]        quarter_rom [0:QUARTER];

  logic signed [15:0] pending_samples [$];
  tone_row_t          directed_rows [$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;

  bit                 stall_request = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        window_left = 0;
  rx_mode_t           rx_mode = RX_ALWAYS;

  sine_tone_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [15:0] quarter_wave_entry(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] poly;
    logic [63:0] s;
    logic [63:0] q15;
    x = 64'(k) << (30 - TAB_BITS);
    x2 = (x * x) >> 30;
    poly = TAYLOR_Q30[5];
    for (int i = 4; i >= 0; i--) begin
      poly = TAYLOR_Q30[i] - ((x2 * poly) >> 30);
    end
    s = (x * poly) >> 30;
    q15 = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (q15 > 64'd32768) begin
      q15 = 64'd32768;
    end
    return q15[15:0];
  endfunction

  // Produce the sample for one tick and advance the phase.
  function automatic logic signed [15:0] next_tone_sample(bit restart);
    logic [1:0]         quad;
    logic [TAB_BITS:0]  addr;
    logic [63:0]        mag;
    logic signed [17:0] val;
    if (restart) begin
      osc_phase = '0;
    end
    quad = osc_phase[PH_BITS-1 -: 2];
    addr = {1'b0, osc_phase[PH_BITS-3 -: TAB_BITS]};
    if (quad[0]) begin
      addr = QUARTER - addr;
    end
    mag = (64'(osc_gain) * 64'(quarter_rom[addr])) >> 15;
    val = $signed({1'b0, mag[16:0]});
    if (quad[1]) begin
      val = -val;
    end
    if (val > 32767) begin
      val = 32767;
    end
    if (val < -32768) begin
      val = -32768;
    end
    osc_phase = osc_phase + PH_BITS'(osc_step);
    return val[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  // Hold valid high until the item is taken; leave it high for a following item.
  task automatic send_tick(bit restart, bit typed, logic signed [15:0] typed_sample);
    logic signed [15:0] predicted;
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    predicted = next_tone_sample(restart);
    pending_samples.push_back(typed ? typed_sample : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back.
  task automatic set_register(row_kind_t which, logic [31:0] data);
    logic [31:0] stored;
    stored = (which == ROW_SET_AMP) ? {16'h0, data[15:0]} : data;
    paddr <= (which == ROW_SET_AMP) ? stg_pkg::ADDR_AMPLITUDE : stg_pkg::ADDR_PHASE_STEP;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (which == ROW_SET_AMP) begin
      osc_gain = data[15:0];
    end else begin
      osc_step = data;
    end
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      report_mismatch(which == ROW_SET_AMP ? "amplitude readback" : "phase_step readback",
                      prdata, stored);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample with nothing pending", 32'(out_sample), 32'h0);
      end else if (out_sample !== pending_samples[0]) begin
        report_mismatch("sample", 32'(out_sample), 32'(pending_samples[0]));
        void'(pending_samples.pop_front());
      end else begin
        void'(pending_samples.pop_front());
      end
    end
  end

  // Result side: a long hold on request, otherwise a stall pattern that changes per window.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_request) begin
      stall_request = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        window_left = $urandom_range(16, 96);
      end
      window_left = window_left - 1;
      case (rx_mode)
        RX_ALWAYS:       out_ready <= 1'b1;
        RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: out_ready <= (window_left % 4 == 0);
        default:         out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    logic [31:0] step_val;
    logic [31:0] gain_val;

    for (int k = 0; k <= QUARTER; k++) begin
      quarter_rom[k] = quarter_wave_entry(k);
    end

    // after reset: zero gain, zero step
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    // quarter-turn step at full scale: zero, positive peak, zero, negative peak, wrap
    directed_rows.push_back('{ROW_SET_AMP, 32'h0000_8000, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_SET_STEP, 32'h4000_0000, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b1, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sh7FFF});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sh8000});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    // gain above range saturates both peaks
    directed_rows.push_back('{ROW_SET_AMP, 32'h0000_FFFF, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b1, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sh7FFF});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sh8000});
    // half scale
    directed_rows.push_back('{ROW_SET_AMP, 32'h0000_4000, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sh4000});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b1, 16'shC000});
    // largest step wraps backward; upper bits of the gain write are dropped
    directed_rows.push_back('{ROW_SET_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_SET_AMP, 32'hABCD_8000, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b1, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b1, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    // odd step, restart in the middle of a sweep
    directed_rows.push_back('{ROW_SET_STEP, 32'h0123_4567, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b1, 1'b1, 16'sd0});
    directed_rows.push_back('{ROW_TICK, 32'h0, 1'b0, 1'b0, 16'sd0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_TICK) begin
        send_tick(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].sample);
      end else begin
        wait_drained();
        set_register(directed_rows[i].kind, directed_rows[i].value);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       step_val = 32'h0;
        1:       step_val = 32'hFFFF_FFFF;
        2:       step_val = 32'h1;
        3:       step_val = $urandom;
        4:       step_val = $urandom_range(1, 32'h00FF_FFFF);
        default: step_val = 32'h8000_0000 >> $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       gain_val = 32'h0;
        1:       gain_val = 32'h0000_8000;
        2:       gain_val = 32'h0000_FFFF;
        3:       gain_val = $urandom;
        default: gain_val = $urandom_range(0, 32768);
      endcase
      if (ph == 0) begin
        step_val = 32'hFFFF_FFFF;
        gain_val = 32'h0000_FFFF;
      end
      set_register(ROW_SET_STEP, step_val);
      set_register(ROW_SET_AMP, gain_val);
      // one phase runs back to back against a long receiver hold
      if (ph == 2) begin
        stall_request = 1'b1;
      end
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        send_tick($urandom_range(0, 9) == 0, 1'b0, 16'sd0);
        if (ph == 5 && n == TICKS_PER_PHASE / 2) begin
          wait_drained();
        end else if (ph != 2) begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            in_restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
